// ----- rtl/ucnsp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ucnsp_pkg;

  // Lookahead window depth and the width of its fill count
  localparam int WIN_DEPTH = 10;
  localparam int FILL_W    = 4;

  // Result queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Characters that steer the translation
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_BSL  = 8'h5C;
  localparam logic [7:0] CHAR_U_LO = 8'h75;
  localparam logic [7:0] CHAR_U_UP = 8'h55;

  // What the back appends after the bytes of a queue entry
  typedef enum logic [1:0] {
    ACT_NONE,  // plain bytes
    ACT_MARK,  // last byte closes the stream
    ACT_LF,    // append a newline that closes the stream
    ACT_BARE   // append a bare end marker
  } ucnsp_act_t;

  // One decision's worth of output bytes plus the end action
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    ucnsp_act_t      act;
  } ucnsp_entry_t;

endpackage
`default_nettype wire

// ----- rtl/ucnsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Source byte channel
interface ucnsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, in_byte, last_byte, input ready);
  modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

// Translated byte channel
interface ucnsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_stream;

  modport source (output valid, out_byte, byte_valid, end_of_stream, input ready);
  modport sink   (input valid, out_byte, byte_valid, end_of_stream, output ready);
endinterface
`default_nettype wire

// ----- rtl/ucn_to_utf8_line_splicer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Translates a source byte stream: \uXXXX and \UXXXXXXXX escapes become UTF-8 (1 to 4 bytes,
// code points above 0x1FFFFF mis-encoded), backslash-newline and backslash-CR-LF vanish, a bad
// escape leaves its backslash as text, and the stream's final result carries end_of_stream,
// with a newline appended when the output does not already end in one, or a bare end marker
// (byte_valid low) when there is nothing to mark. Plain text moves at one byte per cycle while
// the output is ready and the queue has room: the front makes one decision on the head of its
// 10-byte lookahead window per cycle and can take a new byte in the same cycle, while the back
// sends one output byte per cycle from a 2-entry queue. After a byte marked last, no new byte is
// taken until the remaining window decisions and the closing result have been made.
module ucn_to_utf8_line_splicer (
  input  logic         clk,
  input  logic         rst_n,
  ucnsp_in_if.sink     in_chan,
  ucnsp_out_if.source  out_chan
);
  import ucnsp_pkg::*;

  logic         push_valid, push_ready;
  ucnsp_entry_t push_entry;
  logic         pop_valid, pop_ready;
  ucnsp_entry_t pop_entry;

  // Classify source bytes
  ucnsp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // Decouple front and back
  ucnsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // Serialize output bytes
  ucnsp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (pop_valid),
    .q_ready  (pop_ready),
    .q_entry  (pop_entry),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

// ----- rtl/ucnsp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ucnsp_front (
  input  logic                    clk,
  input  logic                    rst_n,
  ucnsp_in_if.sink                in_chan,
  output logic                    push_valid,
  input  logic                    push_ready,
  output ucnsp_pkg::ucnsp_entry_t push_entry
);
  import ucnsp_pkg::*;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Window and stream state
  logic [WIN_DEPTH-1:0][7:0] win_r, win_nxt, win_sh;
  logic [FILL_W-1:0]         fill_r, fill_nxt, fill_after;
  logic                      end_r, end_nxt;
  logic                      any_r, any_nxt;
  logic                      nl_r, nl_nxt;
  logic                      stepem_r, stepem_nxt;
  logic [FILL_W-1:0]         pre_r, pre_nxt;
  logic [3:0][7:0]           hold_bytes_r, hold_bytes_nxt;
  logic [2:0]                hold_cnt_r, hold_cnt_nxt;

  // Decision on the window head
  logic [7:0]        h, s;
  logic [7:0][4:0]   hd;
  logic              long_form, u4_ok, u8_ok;
  logic [31:0]       cp;
  logic [3:0][7:0]   enc_bytes;
  logic [2:0]        enc_cnt;
  logic [FILL_W-1:0] need;
  logic [FILL_W-1:0] dec_need;
  logic              dec_ok, dec_nl, dec_go, dec_final;
  logic [FILL_W-1:0] dec_used;
  logic [2:0]        dec_cnt;
  logic [3:0][7:0]   dec_bytes;
  logic              finish, in_acc;
  ucnsp_act_t        fin_act;

  // Decode the escape digits and encode the code point
  always_comb begin
    h = win_r[0];
    s = win_r[1];
    for (int i = 0; i < 8; i++) begin
      hd[i] = hex_digit(win_r[i+2]);
    end
    long_form = (s == CHAR_U_UP);
    u4_ok = hd[0][4] & hd[1][4] & hd[2][4] & hd[3][4];
    u8_ok = u4_ok & hd[4][4] & hd[5][4] & hd[6][4] & hd[7][4];
    if (long_form) begin
      cp = {hd[0][3:0], hd[1][3:0], hd[2][3:0], hd[3][3:0],
            hd[4][3:0], hd[5][3:0], hd[6][3:0], hd[7][3:0]};
    end else begin
      cp = {16'h0000, hd[0][3:0], hd[1][3:0], hd[2][3:0], hd[3][3:0]};
    end
    enc_bytes = '0;
    if (cp[31:7] == 25'd0) begin
      enc_cnt      = 3'd1;
      enc_bytes[0] = cp[7:0];
    end else if (cp[31:11] == 21'd0) begin
      enc_cnt      = 3'd2;
      enc_bytes[0] = 8'hC0 | cp[13:6];
      enc_bytes[1] = {2'b10, cp[5:0]};
    end else if (!long_form || cp[31:16] == 16'd0) begin
      enc_cnt      = 3'd3;
      enc_bytes[0] = 8'hE0 | cp[19:12];
      enc_bytes[1] = {2'b10, cp[11:6]};
      enc_bytes[2] = {2'b10, cp[5:0]};
    end else begin
      enc_cnt      = 3'd4;
      enc_bytes[0] = 8'hF0 | cp[25:18];
      enc_bytes[1] = {2'b10, cp[17:12]};
      enc_bytes[2] = {2'b10, cp[11:6]};
      enc_bytes[3] = {2'b10, cp[5:0]};
    end
  end

  // Classify the head: literal, escape, splice or wait
  always_comb begin
    logic lit;
    lit       = 1'b0;
    dec_ok    = 1'b0;
    dec_used  = '0;
    dec_cnt   = 3'd0;
    dec_bytes = '0;
    need      = long_form ? 4'd10 : 4'd6;
    // bytes the head needs before it can be decided without the end flag
    if (h != CHAR_BSL) begin
      dec_need = 4'd1;
    end else if (s == CHAR_U_LO || s == CHAR_U_UP) begin
      dec_need = need;
    end else if (s == CHAR_CR) begin
      dec_need = 4'd3;
    end else begin
      dec_need = 4'd2;
    end
    if (fill_r != '0) begin
      if (h != CHAR_BSL) begin
        lit = 1'b1;
      end else if (fill_r < 4'd2) begin
        lit = end_r;
      end else if (s == CHAR_U_LO || s == CHAR_U_UP) begin
        if (fill_r < need) begin
          lit = end_r;
        end else if (long_form ? u8_ok : u4_ok) begin
          dec_ok    = 1'b1;
          dec_used  = need;
          dec_cnt   = enc_cnt;
          dec_bytes = enc_bytes;
        end else begin
          lit = 1'b1;
        end
      end else if (s == CHAR_LF) begin
        dec_ok   = 1'b1;
        dec_used = 4'd2;
      end else if (s == CHAR_CR) begin
        if (fill_r < 4'd3) begin
          lit = end_r;
        end else if (win_r[2] == CHAR_LF) begin
          dec_ok   = 1'b1;
          dec_used = 4'd3;
        end else begin
          lit = 1'b1;
        end
      end else begin
        lit = 1'b1;
      end
    end
    if (lit) begin
      dec_ok       = 1'b1;
      dec_used     = 4'd1;
      dec_cnt      = 3'd1;
      dec_bytes[0] = h;
    end
    // multi-byte encodings end in a continuation byte, never a newline
    dec_nl = (dec_cnt == 3'd1) && (dec_bytes[0] == CHAR_LF);
  end

  // Handshakes and end action
  always_comb begin
    dec_go        = dec_ok && push_ready;
    fill_after    = dec_go ? fill_r - dec_used : fill_r;
    in_chan.ready = !end_r && (fill_after < FILL_W'(WIN_DEPTH));
    in_acc        = in_chan.valid && in_chan.ready;
    finish        = end_r && (fill_r == '0);
    if (any_r && !nl_r) begin
      fin_act = ACT_LF;
    end else if (any_r && stepem_r) begin
      fin_act = ACT_MARK;
    end else begin
      fin_act = ACT_BARE;
    end
    push_valid = finish || (dec_ok && dec_cnt != 3'd0 && (!end_r || hold_cnt_r != 3'd0));
    if (finish) begin
      push_entry = '{bytes: hold_bytes_r, cnt: hold_cnt_r, act: fin_act};
    end else if (!end_r) begin
      push_entry = '{bytes: dec_bytes, cnt: dec_cnt, act: ACT_NONE};
    end else begin
      push_entry = '{bytes: hold_bytes_r, cnt: hold_cnt_r, act: ACT_NONE};
    end
  end

  // Advance the window and append the incoming item
  always_comb begin
    case (dec_go ? dec_used : 4'd0)
      4'd1:    win_sh = win_r >> 8;
      4'd2:    win_sh = win_r >> 16;
      4'd3:    win_sh = win_r >> 24;
      4'd6:    win_sh = win_r >> 48;
      4'd10:   win_sh = win_r >> 80;
      default: win_sh = win_r;
    endcase
    win_nxt = win_sh;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if (in_acc && fill_after == FILL_W'(i)) begin
        win_nxt[i] = in_chan.in_byte;
      end
    end
    fill_nxt = fill_after + (in_acc ? FILL_W'(1) : FILL_W'(0));
  end

  // Track emitted output and hold the newest end-of-stream batch
  always_comb begin
    end_nxt        = end_r | (in_acc & in_chan.last_byte);
    any_nxt        = any_r;
    nl_nxt         = nl_r;
    stepem_nxt     = stepem_r;
    pre_nxt        = pre_r;
    hold_bytes_nxt = hold_bytes_r;
    hold_cnt_nxt   = hold_cnt_r;
    // a head that could be decided from the bytes before the last one
    // belongs to the stream body; once one cannot, the rest is the close
    dec_final      = (dec_need > pre_r);
    if (in_acc && in_chan.last_byte) begin
      pre_nxt = fill_after;
    end
    if (dec_go && end_r) begin
      pre_nxt = dec_final ? '0 : pre_r - dec_used;
    end
    if (dec_go && dec_cnt != 3'd0) begin
      any_nxt = 1'b1;
      nl_nxt  = dec_nl;
      if (end_r) begin
        if (dec_final) begin
          stepem_nxt = 1'b1;
        end
        hold_bytes_nxt = dec_bytes;
        hold_cnt_nxt   = dec_cnt;
      end
    end
    if (finish && push_ready) begin
      end_nxt      = 1'b0;
      any_nxt      = 1'b0;
      nl_nxt       = 1'b0;
      stepem_nxt   = 1'b0;
      pre_nxt      = '0;
      hold_cnt_nxt = 3'd0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    win_r        <= win_nxt;
    hold_bytes_r <= hold_bytes_nxt;
    if (!rst_n) begin
      fill_r     <= '0;
      end_r      <= 1'b0;
      any_r      <= 1'b0;
      nl_r       <= 1'b0;
      stepem_r   <= 1'b0;
      pre_r      <= '0;
      hold_cnt_r <= 3'd0;
    end else begin
      fill_r     <= fill_nxt;
      end_r      <= end_nxt;
      any_r      <= any_nxt;
      nl_r       <= nl_nxt;
      stepem_r   <= stepem_nxt;
      pre_r      <= pre_nxt;
      hold_cnt_r <= hold_cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ucnsp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ucnsp_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push_valid,
  output logic                    push_ready,
  input  ucnsp_pkg::ucnsp_entry_t push_entry,
  output logic                    pop_valid,
  input  logic                    pop_ready,
  output ucnsp_pkg::ucnsp_entry_t pop_entry
);
  import ucnsp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ucnsp_entry_t     mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  // Full and empty flags, pointer advance
  always_comb begin
    push_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
    pop_valid  = (cnt_r != '0);
    pop_entry  = mem_r[rd_ptr_r];
    do_push    = push_valid && push_ready;
    do_pop     = pop_valid && pop_ready;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r + (do_push ? CNT_W'(1) : CNT_W'(0)) - (do_pop ? CNT_W'(1) : CNT_W'(0));
  end

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ucnsp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ucnsp_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  ucnsp_pkg::ucnsp_entry_t q_entry,
  ucnsp_out_if.source             out_chan
);
  import ucnsp_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       byte_valid_r, eos_r;

  logic       tail, load, el_last;
  logic [2:0] total;
  logic [7:0] el_byte;
  logic       el_valid, el_eos;

  // Pick the next item from the head entry
  always_comb begin
    tail = 1'b0;
    unique case (q_entry.act) inside
      ACT_LF, ACT_BARE:   tail = 1'b1;
      ACT_NONE, ACT_MARK: tail = 1'b0;
      default:            tail = 1'b0;
    endcase
    total = q_entry.cnt + {2'b00, tail};
    if (idx_r < q_entry.cnt) begin
      el_byte  = q_entry.bytes[idx_r[1:0]];
      el_valid = 1'b1;
      el_eos   = (q_entry.act == ACT_MARK) && (idx_r == q_entry.cnt - 3'd1);
    end else begin
      el_byte  = (q_entry.act == ACT_LF) ? CHAR_LF : 8'h00;
      el_valid = (q_entry.act == ACT_LF);
      el_eos   = 1'b1;
    end
    load    = q_valid && (!out_valid_r || out_chan.ready);
    el_last = (idx_r + 3'd1 == total);
    q_ready = load && el_last;
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = el_last ? 3'd0 : idx_r + 3'd1;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r   <= el_byte;
      byte_valid_r <= el_valid;
      eos_r        <= el_eos;
    end
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.out_byte      = out_byte_r;
  assign out_chan.byte_valid    = byte_valid_r;
  assign out_chan.end_of_stream = eos_r;

endmodule
`default_nettype wire
